@@ src/buddy_allocator_core_assert.svh @@
// Assertion macros shared by the RTL.
`ifndef BUDDY_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked at the rising clock edge outside reset.
`define BA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at the rising clock edge outside reset.
`define BA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ba_pkg.sv @@
`default_nettype none

package ba_pkg;

    localparam int MAX_ORDER      = 16;
    localparam int SMALLEST_ORDER = 6;
    localparam int MIN_ORDER      = 10;
    localparam int HEADER_BYTES   = 24;

    localparam int SLOT_W     = MAX_ORDER - SMALLEST_ORDER;
    localparam int SLOT_COUNT = 1 << SLOT_W;
    localparam int LINK_W     = SLOT_W + 1;
    localparam int NUM_LISTS  = MAX_ORDER + 1;
    localparam int ORDER_W    = 5;
    localparam int ADDR_W     = 16;
    localparam int SIZE_W     = 17;
    localparam int BYTES_W    = SIZE_W + 1;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [LINK_W-1:0]  link_t;
    typedef logic [ORDER_W-1:0] order_t;
    typedef logic [1:0]         tag_t;

    localparam link_t NIL = link_t'(SLOT_COUNT);

    localparam tag_t TAG_UNUSED   = 2'd0;
    localparam tag_t TAG_AVAIL    = 2'd1;
    localparam tag_t TAG_RESERVED = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_REALLOC = 2'd2;

    typedef struct packed {
        tag_t   tag;
        order_t order;
        link_t  next;
        link_t  prev;
    } slot_word_t;

    typedef struct packed {
        logic tag;
        logic order;
        logic next;
        logic prev;
    } field_mask_t;

    typedef struct packed {
        logic        en;
        slot_t       addr;
        field_mask_t mask;
        slot_word_t  data;
    } slot_wr_t;

    typedef struct packed {
        logic   en;
        order_t idx;
        link_t  data;
    } head_wr_t;

    // Smallest power-of-two order that holds the payload plus its header.
    function automatic order_t req_order(logic [SIZE_W-1:0] size);
        logic [BYTES_W-1:0] bytes;
        logic [BYTES_W:0]   span;
        order_t             k;
        bytes = BYTES_W'(size) + BYTES_W'(HEADER_BYTES);
        k     = order_t'(BYTES_W);
        for (int j = BYTES_W; j >= SMALLEST_ORDER; j--) begin
            span = (BYTES_W+1)'(1) << j;
            if (span >= {1'b0, bytes}) begin
                k = order_t'(j);
            end
        end
        return k;
    endfunction

    function automatic order_t clamp_order(logic [ORDER_W-1:0] v);
        order_t r;
        r = v;
        if (v < order_t'(MIN_ORDER)) begin
            r = order_t'(MIN_ORDER);
        end else if (v > order_t'(MAX_ORDER)) begin
            r = order_t'(MAX_ORDER);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(slot_t s);
        return (ADDR_W'(s) << SMALLEST_ORDER) + ADDR_W'(HEADER_BYTES);
    endfunction

endpackage

`default_nettype wire

@@ src/buddy_allocator_core.sv @@
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_func, s_size, s_addr, s_addr_valid
// m_        out        m_valid/m_ready    m_result_addr, m_status
// cfg_      in         cfg_wr_en          cfg_wr_data (pool order)
//
// A request occupies the core from the idle state that accepts it until its result is stored;
// each split and each merge adds to its walk, and a reallocate that moves its block both
// allocates and frees.
// After reset and after each cfg_wr_en the slot memory is swept, with s_ready low. One
// request is in work at a time; a new one is taken while the previous result waits in the
// output register, and a stalled m_ready holds the next result back.
`default_nettype none

`include "buddy_allocator_core_assert.svh"

module buddy_allocator_core
    import ba_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_func,
    input  wire logic [SIZE_W-1:0] s_size,
    input  wire logic [ADDR_W-1:0] s_addr,
    input  wire logic              s_addr_valid,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ADDR_W-1:0]      m_result_addr,
    output logic [1:0]             m_status,
    input  wire logic              cfg_wr_en,
    input  wire logic [ORDER_W-1:0] cfg_wr_data
);

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DISPATCH = 5'd2;
    localparam logic [4:0] S_F_CHK    = 5'd3;
    localparam logic [4:0] S_R_CHK    = 5'd4;
    localparam logic [4:0] S_A_RD     = 5'd5;
    localparam logic [4:0] S_A_LINK   = 5'd6;
    localparam logic [4:0] S_A_FIX    = 5'd7;
    localparam logic [4:0] S_A_S1     = 5'd8;
    localparam logic [4:0] S_A_S2     = 5'd9;
    localparam logic [4:0] S_A_S3     = 5'd10;
    localparam logic [4:0] S_FR_TEST  = 5'd11;
    localparam logic [4:0] S_FR_CHK   = 5'd12;
    localparam logic [4:0] S_FR_UNL2  = 5'd13;
    localparam logic [4:0] S_FR_HI    = 5'd14;
    localparam logic [4:0] S_FR_PUSH  = 5'd15;
    localparam logic [4:0] S_FR_FIX   = 5'd16;
    localparam logic [4:0] S_DONE     = 5'd17;

    logic [4:0]        state_reg, state_next;
    slot_t             clr_cnt_reg, clr_cnt_next;
    order_t            pool_order_reg, pool_order_next;
    logic [1:0]        func_reg, func_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              addr_valid_reg, addr_valid_next;
    order_t            k_reg, k_next;
    order_t            i_reg, i_next;
    slot_t             s_reg, s_next;
    slot_t             old_reg, old_next;
    order_t            old_k_reg, old_k_next;
    link_t             link_reg, link_next;
    link_t             p_reg, p_next;
    logic              free_after_reg, free_after_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    logic [1:0]        st_reg, st_next;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [1:0]        m_status_reg, m_status_next;

    slot_wr_t   ram_wr;
    slot_t      ram_rd_addr;
    slot_word_t rd;
    head_wr_t   head_wr;
    order_t     head_rd_idx;
    link_t      head_rd;
    logic       srch_found;
    order_t     srch_idx;

    logic [ADDR_W-1:0]  off;
    slot_t              addr_slot;
    logic               addr_ok;
    order_t             k_req;
    logic               alloc_ok;
    logic [BYTES_W-1:0] bytes;
    logic               fits;
    slot_t              upper;
    slot_t              buddy;

    ba_slot_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (rd)
    );

    ba_head_file u_heads (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .init_en    (cfg_wr_en),
        .init_order (clamp_order(cfg_wr_data)),
        .wr         (head_wr),
        .rd_idx     (head_rd_idx),
        .rd_data    (head_rd),
        .srch_from  (k_req),
        .srch_limit (pool_order_reg),
        .srch_found (srch_found),
        .srch_idx   (srch_idx)
    );

    assign off       = addr_reg - ADDR_W'(HEADER_BYTES);
    assign addr_slot = off[ADDR_W-1:SMALLEST_ORDER];
    assign addr_ok   = (addr_reg >= ADDR_W'(HEADER_BYTES))
                       && (off[SMALLEST_ORDER-1:0] == '0)
                       && ((off >> pool_order_reg) == '0);
    assign k_req     = req_order(size_reg);
    assign alloc_ok  = (k_req <= pool_order_reg) && srch_found;
    assign bytes     = BYTES_W'(size_reg) + BYTES_W'(HEADER_BYTES);
    assign fits      = bytes <= (BYTES_W'(1) << rd.order);
    assign upper     = s_reg + (slot_t'(1) << (i_reg - order_t'(SMALLEST_ORDER)));
    assign buddy     = s_reg ^ (slot_t'(1) << (k_reg - order_t'(SMALLEST_ORDER)));
    assign head_rd_idx = (state_reg == S_FR_PUSH) ? k_reg : i_reg;

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        pool_order_next = pool_order_reg;
        func_next       = func_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        addr_valid_next = addr_valid_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        s_next          = s_reg;
        old_next        = old_reg;
        old_k_next      = old_k_reg;
        link_next       = link_reg;
        p_next          = p_reg;
        free_after_next = free_after_reg;
        res_next        = res_reg;
        st_next         = st_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_addr_next     = m_addr_reg;
        m_status_next   = m_status_reg;
        ram_wr          = '0;
        ram_rd_addr     = s_reg;
        head_wr         = '0;

        case (state_reg)
            S_CLEAR: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = clr_cnt_reg;
                ram_wr.mask = '1;
                ram_wr.data.tag   = (clr_cnt_reg == '0) ? TAG_AVAIL : TAG_UNUSED;
                ram_wr.data.order = (clr_cnt_reg == '0) ? pool_order_reg : '0;
                ram_wr.data.next  = NIL;
                ram_wr.data.prev  = NIL;
                clr_cnt_next = clr_cnt_reg + slot_t'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    func_next       = s_func;
                    size_next       = s_size;
                    addr_next       = s_addr;
                    addr_valid_next = s_addr_valid;
                    state_next      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                res_next        = '0;
                st_next         = ST_OK;
                free_after_next = 1'b0;
                ram_rd_addr     = addr_slot;
                s_next          = addr_slot;
                state_next      = S_DONE;
                if (func_reg == FUNC_ALLOC || (func_reg == FUNC_REALLOC && !addr_valid_reg))
                begin
                    if (size_reg == '0) begin
                        st_next = ST_NULL;
                    end else if (!alloc_ok) begin
                        st_next = ST_NOMEM;
                    end else begin
                        k_next     = k_req;
                        i_next     = srch_idx;
                        state_next = S_A_RD;
                    end
                end else if (func_reg == FUNC_FREE) begin
                    if (addr_valid_reg) begin
                        if (!addr_ok) begin
                            st_next = ST_BADADDR;
                        end else begin
                            state_next = S_F_CHK;
                        end
                    end
                end else if (func_reg == FUNC_REALLOC) begin
                    if (!addr_ok) begin
                        st_next = ST_BADADDR;
                    end else begin
                        state_next = S_R_CHK;
                    end
                end
            end
            S_F_CHK: begin
                if (rd.tag != TAG_RESERVED) begin
                    st_next    = ST_BADADDR;
                    state_next = S_DONE;
                end else begin
                    k_next     = rd.order;
                    state_next = S_FR_TEST;
                end
            end
            S_R_CHK: begin
                state_next = S_DONE;
                if (rd.tag != TAG_RESERVED) begin
                    st_next = ST_BADADDR;
                end else if (size_reg == '0) begin
                    st_next    = ST_NULL;
                    k_next     = rd.order;
                    state_next = S_FR_TEST;
                end else if (fits) begin
                    res_next = addr_reg;
                end else if (!alloc_ok) begin
                    st_next = ST_NOMEM;
                end else begin
                    old_next        = s_reg;
                    old_k_next      = rd.order;
                    free_after_next = 1'b1;
                    k_next          = k_req;
                    i_next          = srch_idx;
                    state_next      = S_A_RD;
                end
            end
            S_A_RD: begin
                s_next      = head_rd[SLOT_W-1:0];
                ram_rd_addr = head_rd[SLOT_W-1:0];
                state_next  = S_A_LINK;
            end
            S_A_LINK: begin
                // The block is the head of its list, so only its successor needs patching.
                link_next    = rd.next;
                head_wr.en   = 1'b1;
                head_wr.idx  = i_reg;
                head_wr.data = rd.next;
                if (i_reg == k_reg) begin
                    ram_wr.en       = 1'b1;
                    ram_wr.addr     = s_reg;
                    ram_wr.mask.tag = 1'b1;
                    ram_wr.data.tag = TAG_RESERVED;
                    res_next        = slot_addr(s_reg);
                    state_next      = S_A_FIX;
                end else begin
                    ram_wr.en        = (rd.next != NIL);
                    ram_wr.addr      = rd.next[SLOT_W-1:0];
                    ram_wr.mask.prev = 1'b1;
                    ram_wr.data.prev = NIL;
                    i_next           = i_reg - order_t'(1);
                    state_next       = S_A_S1;
                end
            end
            S_A_FIX: begin
                ram_wr.en        = (link_reg != NIL);
                ram_wr.addr      = link_reg[SLOT_W-1:0];
                ram_wr.mask.prev = 1'b1;
                ram_wr.data.prev = NIL;
                if (free_after_reg) begin
                    s_next     = old_reg;
                    k_next     = old_k_reg;
                    state_next = S_FR_TEST;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_A_S1: begin
                // Lower half goes on the list first, then the upper half in front of it.
                link_next         = head_rd;
                ram_wr.en         = 1'b1;
                ram_wr.addr       = s_reg;
                ram_wr.mask       = '1;
                ram_wr.data.tag   = TAG_AVAIL;
                ram_wr.data.order = i_reg;
                ram_wr.data.next  = head_rd;
                ram_wr.data.prev  = link_t'(upper);
                state_next        = S_A_S2;
            end
            S_A_S2: begin
                ram_wr.en         = 1'b1;
                ram_wr.addr       = upper;
                ram_wr.mask       = '1;
                ram_wr.data.tag   = TAG_AVAIL;
                ram_wr.data.order = i_reg;
                ram_wr.data.next  = link_t'(s_reg);
                ram_wr.data.prev  = NIL;
                head_wr.en        = 1'b1;
                head_wr.idx       = i_reg;
                head_wr.data      = link_t'(upper);
                state_next        = S_A_S3;
            end
            S_A_S3: begin
                ram_wr.en        = (link_reg != NIL);
                ram_wr.addr      = link_reg[SLOT_W-1:0];
                ram_wr.mask.prev = 1'b1;
                ram_wr.data.prev = link_t'(s_reg);
                state_next       = S_A_RD;
            end
            S_FR_TEST: begin
                if (k_reg < pool_order_reg) begin
                    ram_rd_addr = buddy;
                    state_next  = S_FR_CHK;
                end else begin
                    state_next = S_FR_PUSH;
                end
            end
            S_FR_CHK: begin
                if (rd.tag != TAG_AVAIL || rd.order != k_reg) begin
                    state_next = S_FR_PUSH;
                end else begin
                    link_next = rd.next;
                    p_next    = rd.prev;
                    if (rd.prev != NIL) begin
                        ram_wr.en        = 1'b1;
                        ram_wr.addr      = rd.prev[SLOT_W-1:0];
                        ram_wr.mask.next = 1'b1;
                        ram_wr.data.next = rd.next;
                    end else begin
                        head_wr.en   = 1'b1;
                        head_wr.idx  = k_reg;
                        head_wr.data = rd.next;
                    end
                    state_next = S_FR_UNL2;
                end
            end
            S_FR_UNL2: begin
                ram_wr.en        = (link_reg != NIL);
                ram_wr.addr      = link_reg[SLOT_W-1:0];
                ram_wr.mask.prev = 1'b1;
                ram_wr.data.prev = p_reg;
                state_next       = S_FR_HI;
            end
            S_FR_HI: begin
                // The upper of the two halves disappears inside the merged block.
                ram_wr.en         = 1'b1;
                ram_wr.addr       = (buddy > s_reg) ? buddy : s_reg;
                ram_wr.mask.tag   = 1'b1;
                ram_wr.mask.order = 1'b1;
                ram_wr.data.tag   = TAG_UNUSED;
                ram_wr.data.order = '0;
                s_next            = (buddy < s_reg) ? buddy : s_reg;
                k_next            = k_reg + order_t'(1);
                state_next        = S_FR_TEST;
            end
            S_FR_PUSH: begin
                link_next         = head_rd;
                ram_wr.en         = 1'b1;
                ram_wr.addr       = s_reg;
                ram_wr.mask       = '1;
                ram_wr.data.tag   = TAG_AVAIL;
                ram_wr.data.order = k_reg;
                ram_wr.data.next  = head_rd;
                ram_wr.data.prev  = NIL;
                head_wr.en        = 1'b1;
                head_wr.idx       = k_reg;
                head_wr.data      = link_t'(s_reg);
                state_next        = S_FR_FIX;
            end
            S_FR_FIX: begin
                ram_wr.en        = (link_reg != NIL);
                ram_wr.addr      = link_reg[SLOT_W-1:0];
                ram_wr.mask.prev = 1'b1;
                ram_wr.data.prev = link_t'(s_reg);
                state_next       = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = res_reg;
                    m_status_next = st_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            pool_order_next = clamp_order(cfg_wr_data);
            clr_cnt_next    = '0;
            state_next      = S_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            pool_order_reg <= order_t'(MAX_ORDER);
            m_valid_reg    <= 1'b0;
            free_after_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pool_order_reg <= pool_order_next;
            m_valid_reg    <= m_valid_next;
            free_after_reg <= free_after_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        addr_valid_reg <= addr_valid_next;
        k_reg          <= k_next;
        i_reg          <= i_next;
        s_reg          <= s_next;
        old_reg        <= old_next;
        old_k_reg      <= old_k_next;
        link_reg       <= link_next;
        p_reg          <= p_next;
        res_reg        <= res_next;
        st_reg         <= st_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_result_addr = m_addr_reg;
    assign m_status      = m_status_reg;

    `BA_ASSERT_NOW(a_fail_no_addr, aclk, aresetn, m_valid && m_status != ST_OK, m_result_addr == '0, "failed request carries an address")
    `BA_ASSERT_NOW(a_wr_in_pool, aclk, aresetn, ram_wr.en && state_reg != S_CLEAR, (ram_wr.addr >> (pool_order_reg - order_t'(SMALLEST_ORDER))) == '0, "slot write outside the pool")
    `BA_ASSERT_NEXT(a_accept_dispatch, aclk, aresetn, s_valid && s_ready && !cfg_wr_en, state_reg == S_DISPATCH, "accepted request not dispatched")

endmodule

`default_nettype wire

@@ src/ba_slot_ram.sv @@
`default_nettype none

module ba_slot_ram
    import ba_pkg::*;
(
    input  wire logic       aclk,
    input  wire slot_wr_t   wr,
    input  wire slot_t      rd_addr,
    output slot_word_t      rd_data
);

    tag_t   tag_mem   [SLOT_COUNT];
    order_t order_mem [SLOT_COUNT];
    link_t  next_mem  [SLOT_COUNT];
    link_t  prev_mem  [SLOT_COUNT];

    slot_word_t rd_data_reg;

    // Each field has its own write enable so a link can be patched alone.
    always_ff @(posedge aclk) begin
        if (wr.en && wr.mask.tag) begin
            tag_mem[wr.addr] <= wr.data.tag;
        end
        if (wr.en && wr.mask.order) begin
            order_mem[wr.addr] <= wr.data.order;
        end
        if (wr.en && wr.mask.next) begin
            next_mem[wr.addr] <= wr.data.next;
        end
        if (wr.en && wr.mask.prev) begin
            prev_mem[wr.addr] <= wr.data.prev;
        end
        rd_data_reg.tag   <= tag_mem[rd_addr];
        rd_data_reg.order <= order_mem[rd_addr];
        rd_data_reg.next  <= next_mem[rd_addr];
        rd_data_reg.prev  <= prev_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/ba_head_file.sv @@
`default_nettype none

module ba_head_file
    import ba_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     init_en,
    input  wire order_t   init_order,
    input  wire head_wr_t wr,
    input  wire order_t   rd_idx,
    output link_t         rd_data,
    input  wire order_t   srch_from,
    input  wire order_t   srch_limit,
    output logic          srch_found,
    output order_t        srch_idx
);

    link_t head_reg [NUM_LISTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                head_reg[i] <= (i == MAX_ORDER) ? link_t'(0) : NIL;
            end
        end else if (init_en) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                head_reg[i] <= (order_t'(i) == init_order) ? link_t'(0) : NIL;
            end
        end else if (wr.en) begin
            head_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_data = head_reg[rd_idx];

    // The lowest non-empty list within the requested range of orders.
    always_comb begin
        srch_found = 1'b0;
        srch_idx   = '0;
        for (int i = NUM_LISTS - 1; i >= 0; i--) begin
            if (order_t'(i) >= srch_from && order_t'(i) <= srch_limit
                    && !head_reg[i][SLOT_W]) begin
                srch_found = 1'b1;
                srch_idx   = order_t'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ bench/buddy_allocator_core_test.sv @@
`default_nettype none

module buddy_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ba_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] result_addr;
        logic [1:0]        status;
    } outcome_t;

    // Software image of the allocator: slot table, free lists and the expected results.
    class alloc_scoreboard;
        int unsigned pool_ord;
        tag_t        tag_of[SLOT_COUNT];
        int unsigned ord_of[SLOT_COUNT];
        int unsigned nxt[SLOT_COUNT];
        int unsigned prv[SLOT_COUNT];
        int unsigned head[NUM_LISTS];
        outcome_t    pending[$];
        int          errors;
        logic [ADDR_W-1:0] live[$];

        function void set_pool(int unsigned v);
            pool_ord = (v < MIN_ORDER) ? MIN_ORDER : (v > MAX_ORDER) ? MAX_ORDER : v;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                tag_of[i] = TAG_UNUSED;
                ord_of[i] = 0;
            end
            for (int i = 0; i < NUM_LISTS; i++) head[i] = SLOT_COUNT;
            tag_of[0] = TAG_AVAIL;
            ord_of[0] = pool_ord;
            nxt[0] = SLOT_COUNT;
            prv[0] = SLOT_COUNT;
            head[pool_ord] = 0;
            live.delete();
        endfunction

        function void push_free(int unsigned k, int unsigned s);
            nxt[s] = head[k];
            prv[s] = SLOT_COUNT;
            if (head[k] < SLOT_COUNT) prv[head[k]] = s;
            head[k] = s;
        endfunction

        function void unlink(int unsigned k, int unsigned s);
            if (prv[s] < SLOT_COUNT) nxt[prv[s]] = nxt[s];
            else head[k] = nxt[s];
            if (nxt[s] < SLOT_COUNT) prv[nxt[s]] = prv[s];
        endfunction

        function bit take_block(int unsigned size, output int unsigned slot);
            int unsigned bytes, k, i, s, up;
            bytes = size + HEADER_BYTES;
            k = SMALLEST_ORDER;
            while (k <= pool_ord && (1 << k) < bytes) k++;
            if (k > pool_ord) return 0;
            i = k;
            while (i <= pool_ord && head[i] == SLOT_COUNT) i++;
            if (i > pool_ord) return 0;
            while (i > k) begin
                s = head[i];
                unlink(i, s);
                i--;
                up = s + (1 << (i - SMALLEST_ORDER));
                tag_of[s] = TAG_AVAIL;
                ord_of[s] = i;
                tag_of[up] = TAG_AVAIL;
                ord_of[up] = i;
                push_free(i, s);
                push_free(i, up);
            end
            s = head[k];
            unlink(k, s);
            tag_of[s] = TAG_RESERVED;
            slot = s;
            return 1;
        endfunction

        function void give_back(int unsigned s);
            int unsigned k, b, hi;
            k = ord_of[s];
            while (k < pool_ord) begin
                b = s ^ (1 << (k - SMALLEST_ORDER));
                if (b >= SLOT_COUNT || tag_of[b] != TAG_AVAIL || ord_of[b] != k) break;
                unlink(k, b);
                hi = (b > s) ? b : s;
                if (b < s) s = b;
                tag_of[hi] = TAG_UNUSED;
                ord_of[hi] = 0;
                k++;
                ord_of[s] = k;
            end
            tag_of[s] = TAG_AVAIL;
            push_free(k, s);
        endfunction

        function bit lookup(int unsigned addr, output int unsigned slot);
            int unsigned off;
            if (addr < HEADER_BYTES) return 0;
            off = addr - HEADER_BYTES;
            if (off % (1 << SMALLEST_ORDER) != 0) return 0;
            slot = off >> SMALLEST_ORDER;
            if (slot >= (1 << (pool_ord - SMALLEST_ORDER))) return 0;
            return tag_of[slot] == TAG_RESERVED;
        endfunction

        function logic [ADDR_W-1:0] payload_of(int unsigned s);
            return ADDR_W'((s << SMALLEST_ORDER) + HEADER_BYTES);
        endfunction

        function void forget(logic [ADDR_W-1:0] a);
            foreach (live[i]) if (live[i] == a) begin
                live.delete(i);
                return;
            end
        endfunction

        // Notes an accepted request and queues the result it must produce.
        function void note_request(logic [1:0] fn, int unsigned size,
                                   logic [ADDR_W-1:0] addr, bit av);
            outcome_t o;
            int unsigned s, ns;
            o.result_addr = '0;
            o.status = ST_OK;
            if (fn == FUNC_ALLOC || (fn == FUNC_REALLOC && !av)) begin
                if (size == 0) o.status = ST_NULL;
                else if (take_block(size, ns)) begin
                    o.result_addr = payload_of(ns);
                    live.push_back(o.result_addr);
                end else o.status = ST_NOMEM;
            end else if (fn == FUNC_FREE) begin
                if (av) begin
                    if (lookup(addr, s)) begin
                        give_back(s);
                        forget(addr);
                    end else o.status = ST_BADADDR;
                end
            end else if (fn == FUNC_REALLOC) begin
                if (!lookup(addr, s)) o.status = ST_BADADDR;
                else if (size == 0) begin
                    give_back(s);
                    forget(addr);
                    o.status = ST_NULL;
                end else if (size + HEADER_BYTES <= (1 << ord_of[s])) begin
                    o.result_addr = addr;
                end else if (take_block(size, ns)) begin
                    give_back(s);
                    forget(addr);
                    o.result_addr = payload_of(ns);
                    live.push_back(o.result_addr);
                end else o.status = ST_NOMEM;
            end
            pending.push_back(o);
        endfunction

        function void check_result(logic [ADDR_W-1:0] ra, logic [1:0] st);
            outcome_t o;
            if (pending.size() == 0) begin
                $error("unexpected result: result_addr %0d status %0d", ra, st);
                errors++;
                return;
            end
            o = pending.pop_front();
            if (ra !== o.result_addr) begin
                $error("result_addr: expected %0d, actual %0d", o.result_addr, ra);
                errors++;
            end
            if (st !== o.status) begin
                $error("status: expected %0d, actual %0d", o.status, st);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_func = '0;
    logic [SIZE_W-1:0] s_size = '0;
    logic [ADDR_W-1:0] s_addr = '0;
    logic s_addr_valid = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [ADDR_W-1:0] m_result_addr;
    logic [1:0] m_status;
    logic cfg_wr_en = 0;
    logic [ORDER_W-1:0] cfg_wr_data = '0;

    alloc_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_recv = 0;
    int quiet_cycles = 0;

    buddy_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_size(s_size),
        .s_addr(s_addr), .s_addr_valid(s_addr_valid),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_addr(m_result_addr),
        .m_status(m_status), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // Result side: random stalls, plus an explicit long hold-off when requested.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_result_addr, m_status);
        if (hold_recv > 0) begin
            hold_recv <= hold_recv - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: the sweep after reset or a pool write is quiet, so the limit must exceed it.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("buddy_allocator_core verification failed");
            $finish;
        end
    end

    // Valid stays up after an accept; the next request, an idle cycle or a drain replaces it.
    task automatic send_request(logic [1:0] fn, int unsigned size,
                                logic [ADDR_W-1:0] addr, bit av);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_func <= fn;
        s_size <= SIZE_W'(size);
        s_addr <= addr;
        s_addr_valid <= av;
        do @(posedge aclk); while (!s_ready);
        board.note_request(fn, size, addr, av);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_pool(int unsigned v);
        drain();
        cfg_wr_en <= 1;
        cfg_wr_data <= ORDER_W'(v);
        @(posedge aclk);
        cfg_wr_en <= 0;
        board.set_pool(v);
    endtask

    // Mostly sensible sizes, sometimes huge ones that cannot fit.
    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return 0;
        if (r < 60) return $urandom_range(1, 200);
        if (r < 90) return $urandom_range(1, 2000);
        if (r < 97) return $urandom_range(1, 9000);
        return $urandom_range(0, 131071);
    endfunction

    task automatic random_request();
        int unsigned r;
        logic [ADDR_W-1:0] a;
        int idx;
        r = $urandom_range(99);
        if (board.live.size() != 0) begin
            idx = $urandom_range(board.live.size() - 1);
            a = board.live[idx];
        end else a = ADDR_W'(HEADER_BYTES);
        if (r < 40) send_request(FUNC_ALLOC, pick_size(), ADDR_W'($urandom), $urandom_range(1));
        else if (r < 70) send_request(FUNC_FREE, 0, a, 1);
        else if (r < 85) send_request(FUNC_REALLOC, pick_size(), a, 1);
        else if (r < 90) send_request(FUNC_REALLOC, pick_size(), a, 0);
        else if (r < 94) send_request(FUNC_FREE, $urandom_range(131071), a, 0);
        else if (r < 98) send_request(2'($urandom_range(1, 2)), pick_size(),
                                      ADDR_W'($urandom), 1);
        else send_request(2'd3, $urandom_range(131071), ADDR_W'($urandom),
                          $urandom_range(1));
    endtask

    initial begin
        logic [ADDR_W-1:0] a;
        board.set_pool(MAX_ORDER);
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // Directed: extremes, every operation and the odd cases.
        send_request(FUNC_ALLOC, 0, '0, 0);
        send_request(FUNC_ALLOC, 131071, '0, 0);
        send_request(FUNC_ALLOC, 65536, '0, 0);
        send_request(FUNC_ALLOC, 65536 - HEADER_BYTES, '0, 0);
        send_request(FUNC_FREE, 0, ADDR_W'(HEADER_BYTES), 1);
        send_request(FUNC_ALLOC, 1, '0, 0);
        send_request(FUNC_ALLOC, 40, '0, 0);
        send_request(FUNC_ALLOC, 41, '0, 0);
        a = board.live[0];
        send_request(FUNC_REALLOC, 30, a, 1);
        send_request(FUNC_REALLOC, 500, a, 1);
        send_request(FUNC_REALLOC, 131071, board.live[0], 1);
        send_request(FUNC_FREE, 0, '0, 0);
        send_request(FUNC_FREE, 0, 16'd5, 1);
        send_request(FUNC_FREE, 0, 16'd25, 1);
        send_request(FUNC_FREE, 0, 16'hFFFF, 1);
        send_request(FUNC_REALLOC, 7, 16'd88, 1);
        send_request(FUNC_REALLOC, 0, board.live[0], 1);
        send_request(FUNC_REALLOC, 100, '0, 0);
        send_request(2'd3, 131071, 16'hFFFF, 1);
        while (board.live.size() != 0) send_request(FUNC_FREE, 0, board.live[0], 1);
        write_pool(0);
        send_request(FUNC_ALLOC, 1000, '0, 0);
        send_request(FUNC_ALLOC, 1, '0, 0);
        write_pool(31);

        // Random phases under different idling and pool sizes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 50; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 50; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            if (ph == 2) hold_recv = 600;
            for (int n = 0; n < 200; n++) random_request();
            if (ph == 1) drain();
            write_pool((ph == 3) ? 10 : (ph == 5) ? 16 : $urandom_range(9, 17));
        end

        drain();
        if (board.errors == 0) $display("buddy_allocator_core verification clean");
        else $display("buddy_allocator_core verification failed");
        $finish;
    end
endmodule

`default_nettype wire
